// File: rtl/core/bincoef_pkg.sv
// ----------------------------------------------------------------------------
// bincoef_pkg: shared types and constants for the binomial coefficient core
// Beat payload structs, controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package bincoef_pkg;

    // field widths
    localparam int unsigned N_W    = 6;
    localparam int unsigned COEF_W = 32;
    localparam int unsigned ACC_W  = 64;
    localparam int unsigned CNT_W  = $clog2(ACC_W);

    // default bound on n that keeps the accumulator within 64 bits
    localparam int unsigned MAX_N_DEF = 60;

    // input beat
    typedef struct packed {
        logic [N_W-1:0] n_total;
        logic [N_W-1:0] k_chosen;
    } t_in;

    // result beat
    typedef struct packed {
        logic [COEF_W-1:0] coefficient;
        logic              truncated;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch a new input beat
        logic mul;       // acc *= (n - i + 1), clear divider
        logic div_step;  // one restoring-divide bit
        logic emit;      // capture the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic special;   // result known without the loop
        logic loop_done; // i has passed k
        logic bit_last;  // last divider bit this cycle
    } t_sts;

endpackage : bincoef_pkg

`default_nettype wire

// File: rtl/core/bincoef_dp.sv
// ----------------------------------------------------------------------------
// bincoef_dp: binomial coefficient datapath
// Input folding, 64x6 multiply and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bincoef_dp #(
    parameter int unsigned MAX_N = bincoef_pkg::MAX_N_DEF
) (
    input  wire logic              i_clk,
    input  wire bincoef_pkg::t_in  i_item,
    input  wire bincoef_pkg::t_cmd i_cmd,
    output bincoef_pkg::t_sts      o_sts,
    output bincoef_pkg::t_out      o_result
);

    localparam int unsigned N_W   = bincoef_pkg::N_W;
    localparam int unsigned ACC_W = bincoef_pkg::ACC_W;
    localparam int unsigned CNT_W = bincoef_pkg::CNT_W;
    localparam int unsigned CW    = bincoef_pkg::COEF_W;
    localparam logic [N_W:0] MAX_N_V = (N_W+1)'(MAX_N);

    logic [N_W-1:0]   r_n, r_k, r_i, r_rem;
    logic [ACC_W-1:0] r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_spec;
    bincoef_pkg::t_out r_spec_res, r_res;

    logic [N_W-1:0]   n_k_fold;
    logic             n_spec;
    bincoef_pkg::t_out n_spec_res;
    logic [N_W-1:0]   mul_factor;
    logic [ACC_W-1:0] mul_prod;
    logic [N_W:0]     rem_sh, rem_sub;
    logic             q_bit;

    // special cases and k folding on the incoming beat
    always_comb begin
        if ({1'b0, i_item.k_chosen, 1'b0} > {2'b00, i_item.n_total}) begin
            n_k_fold = i_item.n_total - i_item.k_chosen;
        end else begin
            n_k_fold = i_item.k_chosen;
        end
        n_spec     = 1'b1;
        n_spec_res = '0;
        if ({1'b0, i_item.n_total} > MAX_N_V) begin
            n_spec_res.truncated = 1'b1;
        end else if (i_item.k_chosen > i_item.n_total) begin
            n_spec_res = '0;
        end else if (n_k_fold == '0) begin
            n_spec_res.coefficient = CW'(1);
        end else begin
            n_spec = 1'b0;
        end
    end

    // multiply by the next numerator term
    assign mul_factor = r_n - r_i + N_W'(1);
    assign mul_prod   = r_acc * {{(ACC_W-N_W){1'b0}}, mul_factor};

    // restoring divide step, quotient shifts into the accumulator
    assign rem_sh  = {r_rem, r_acc[ACC_W-1]};
    assign q_bit   = rem_sh >= {1'b0, r_i};
    assign rem_sub = q_bit ? (rem_sh - {1'b0, r_i}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n        <= i_item.n_total;
            r_k        <= n_k_fold;
            r_i        <= N_W'(2);
            r_acc      <= {{(ACC_W-N_W){1'b0}}, i_item.n_total};
            r_spec     <= n_spec;
            r_spec_res <= n_spec_res;
        end
        if (i_cmd.mul) begin
            r_acc <= mul_prod;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_acc <= {r_acc[ACC_W-2:0], q_bit};
            r_rem <= rem_sub[N_W-1:0];
            r_cnt <= r_cnt + CNT_W'(1);
            if (o_sts.bit_last) begin
                r_i <= r_i + N_W'(1);
            end
        end
        if (i_cmd.emit) begin
            if (r_spec) begin
                r_res <= r_spec_res;
            end else begin
                r_res.coefficient <= r_acc[CW-1:0];
                r_res.truncated   <= |r_acc[ACC_W-1:CW];
            end
        end
    end

    // status back to the controller
    assign o_sts.special   = r_spec;
    assign o_sts.loop_done = r_i > r_k;
    assign o_sts.bit_last  = r_cnt == CNT_W'(ACC_W-1);
    assign o_result        = r_res;

endmodule : bincoef_dp

`default_nettype wire

// File: rtl/core/bincoef_ctrl.sv
// ----------------------------------------------------------------------------
// bincoef_ctrl: binomial coefficient controller
// Sequences the loop passes and drives busy and the done strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module bincoef_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire bincoef_pkg::t_sts i_sts,
    output bincoef_pkg::t_cmd      o_cmd,
    output logic                   o_busy,
    output logic                   o_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.special || i_sts.loop_done) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   n_state = S_DIV;
            S_DIV: begin
                if (i_sts.bit_last) n_state = S_CHECK;
            end
            S_EMIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state and done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= r_state == S_EMIT;
        end
    end

    // datapath commands
    assign o_cmd.load     = (r_state == S_IDLE) && i_start;
    assign o_cmd.mul      = r_state == S_MUL;
    assign o_cmd.div_step = r_state == S_DIV;
    assign o_cmd.emit     = r_state == S_EMIT;
    assign o_busy         = r_state != S_IDLE;
    assign o_done         = r_done;

endmodule : bincoef_ctrl

`default_nettype wire

// File: rtl/core/binomial_coefficient_core.sv
// ----------------------------------------------------------------------------
// binomial_coefficient_core: C(n,k) by the multiplicative method
// Controller plus a datapath with a 64-bit accumulator and serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item and raise start; the beat is taken on a clock edge where
//   start is high and busy is low. busy stays high while the item is worked.
//   The result appears on o_result, marked by o_done for exactly one cycle;
//   o_result then holds until the next result; the receiver cannot stall the core.
// Sequence: after the accept edge the item is checked; n above MAX_N,
//   k above n, or folded k of zero go straight to emit. Otherwise each
//   loop pass is a check, a multiply by the next numerator term and the
//   one-bit-a-cycle restoring divider, until i passes k' = min(k, n-k);
//   then the emit state, from which o_done is registered.
// Throughput: one item at a time; the next start is taken in the cycle
//   o_done is high.
// Reset: synchronous, active low; returns the controller to idle and
//   drops busy and o_done. An item in flight is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_coefficient_core #(
    parameter int unsigned MAX_N = bincoef_pkg::MAX_N_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire bincoef_pkg::t_in i_item,
    output logic                  busy,
    output logic                  o_done,
    output bincoef_pkg::t_out     o_result
);

    bincoef_pkg::t_cmd cmd;
    bincoef_pkg::t_sts sts;

    // sequencing
    bincoef_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // arithmetic
    bincoef_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .i_clk    (i_clk),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule : binomial_coefficient_core

`default_nettype wire

// File: rtl/core/bincoef_chk.sv
// ----------------------------------------------------------------------------
// bincoef_chk: port-level checks for binomial_coefficient_core
// Start/busy/done sequencing as seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bincoef_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done
);

    // an accepted beat makes the core busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepting a beat");

    // done is a single-cycle strobe
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done strobe longer than one cycle");

    // a result shows only once the core is idle again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("done while still busy");

    // a result follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("done without preceding work");

endmodule : bincoef_chk

bind binomial_coefficient_core bincoef_chk u_bincoef_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);

`default_nettype wire
